// File: design/assert_macros.svh
// Assertion macros used by the checker file of the classifier.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge out of reset.
`define MAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mac_cls_pkg.sv
// Package of the address classifier: table sizes, request and verdict codes,
// and the word types of both channels. No dependencies.
`timescale 1ns / 1ps

package mac_cls_pkg;

    localparam int TGT_ENTRIES = 16;
    localparam int PFX_ENTRIES = 16;
    localparam int TGT_AW = (TGT_ENTRIES > 1) ? $clog2(TGT_ENTRIES) : 1;
    localparam int PFX_AW = (PFX_ENTRIES > 1) ? $clog2(PFX_ENTRIES) : 1;

    localparam int ADDR_W     = 48;
    localparam int ADDR_DIGITS = 12;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_EXACT  = 2'd0;
    localparam logic [1:0] REQ_LOAD_PREFIX = 2'd1;
    localparam logic [1:0] REQ_CLASSIFY    = 2'd2;

    // Verdict codes.
    localparam logic [1:0] V_NONE   = 2'd0;
    localparam logic [1:0] V_EXACT  = 2'd1;
    localparam logic [1:0] V_PREFIX = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [47:0]       address;
        logic [3:0]        entry_index;
        logic              entry_valid;
        logic [3:0]        prefix_digits;
        logic [7:0]        device_class;
        logic signed [7:0] signal_dbm;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [47:0]       hit_address;
        logic signed [7:0] hit_signal_dbm;
        logic [7:0]        hit_class;
        logic [31:0]       scan_count;
        logic [31:0]       exact_count;
        logic [31:0]       prefix_count;
    } out_word_t;

    // One prefix table entry as stored in memory.
    typedef struct packed {
        logic [47:0] prefix;
        logic [3:0]  digits;
        logic [7:0]  dev_class;
    } pfx_entry_t;

    // Status from the scan engine to the channel logic.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

endpackage

// File: design/mac_cls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mac_cls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mac_cls_engine.sv
// Scan engine: owns both table memories, their valid bits and the counters,
// and walks the tables for a classify word. Depends on mac_cls_pkg, mac_cls_ram.
`timescale 1ns / 1ps

module mac_cls_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mac_cls_pkg::in_word_t item,
    input  logic                  prefix_en,
    input  logic                  res_take,
    output mac_cls_pkg::eng_stat_t stat,
    output mac_cls_pkg::out_word_t res
);
    import mac_cls_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TSCAN = 2'd1;
    localparam logic [1:0] S_PSCAN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // True when the top digits of the address equal those of the prefix.
    function automatic logic prefix_hit(input logic [ADDR_W-1:0] a,
                                        input logic [ADDR_W-1:0] p,
                                        input logic [3:0] n);
        logic [ADDR_W-1:0] mask;
        mask = '0;
        for (int d = 0; d < ADDR_DIGITS; d++)
        begin
            if (4'(d) < n)
            begin
                mask[ADDR_W-1-4*d -: 4] = 4'hF;
            end
        end
        return (n <= 4'(ADDR_DIGITS)) && (((a ^ p) & mask) == '0);
    endfunction

    logic [1:0]             state_reg, state_next;
    logic [TGT_AW-1:0]      t_ptr_reg, t_ptr_next;
    logic [PFX_AW-1:0]      p_ptr_reg, p_ptr_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   cmp_last_reg, cmp_last_next;
    logic                   ent_vld_reg, ent_vld_next;
    logic [TGT_ENTRIES-1:0] tv_reg, tv_next;
    logic [PFX_ENTRIES-1:0] pv_reg, pv_next;
    logic [31:0]            scans_reg, scans_next;
    logic [31:0]            exact_reg, exact_next;
    logic [31:0]            pfx_cnt_reg, pfx_cnt_next;

    // Payload of the word under classification.
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic signed [7:0]      sig_reg, sig_next;
    logic [1:0]             verdict_reg, verdict_next;
    logic [7:0]             class_reg, class_next;

    // Memory ports.
    logic                   t_we, p_we;
    logic [TGT_AW-1:0]      t_waddr;
    logic [PFX_AW-1:0]      p_waddr;
    logic [ADDR_W-1:0]      t_rdata;
    pfx_entry_t             p_wdata, p_rdata;
    logic                   t_hit, p_hit;

    mac_cls_ram #(.WIDTH(ADDR_W), .DEPTH(TGT_ENTRIES)) u_tgt_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (item.address),
        .raddr (t_ptr_reg),
        .rdata (t_rdata)
    );

    mac_cls_ram #(.WIDTH($bits(pfx_entry_t)), .DEPTH(PFX_ENTRIES)) u_pfx_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_ptr_reg),
        .rdata (p_rdata)
    );

    // Load decode: a slot past the end of a table is ignored.
    assign t_waddr = TGT_AW'(item.entry_index);
    assign p_waddr = PFX_AW'(item.entry_index);
    assign t_we = start && (item.req_type == REQ_LOAD_EXACT)
                  && (int'(item.entry_index) < TGT_ENTRIES);
    assign p_we = start && (item.req_type == REQ_LOAD_PREFIX)
                  && (int'(item.entry_index) < PFX_ENTRIES);
    assign p_wdata = '{prefix: item.address, digits: item.prefix_digits,
                       dev_class: item.device_class};

    // Compare of the entry whose read data is now on the memory output.
    assign t_hit = ent_vld_reg && (t_rdata == addr_reg);
    assign p_hit = ent_vld_reg && prefix_hit(addr_reg, p_rdata.prefix, p_rdata.digits);

    // Sequencer: issue one read per cycle, compare each entry in the cycle after its read.
    always_comb
    begin
        state_next      = state_reg;
        t_ptr_next      = t_ptr_reg;
        p_ptr_next      = p_ptr_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_last_next   = cmp_last_reg;
        ent_vld_next    = ent_vld_reg;
        tv_next         = tv_reg;
        pv_next         = pv_reg;
        scans_next      = scans_reg;
        exact_next      = exact_reg;
        pfx_cnt_next    = pfx_cnt_reg;
        addr_next       = addr_reg;
        sig_next        = sig_reg;
        verdict_next    = verdict_reg;
        class_next      = class_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (t_we)
                begin
                    tv_next[t_waddr] = item.entry_valid;
                end
                if (p_we)
                begin
                    pv_next[p_waddr] = item.entry_valid;
                end
                if (start && (item.req_type == REQ_CLASSIFY))
                begin
                    state_next      = S_TSCAN;
                    scans_next      = scans_reg + 32'd1;
                    addr_next       = item.address;
                    sig_next        = item.signal_dbm;
                    verdict_next    = V_NONE;
                    class_next      = 8'd0;
                    t_ptr_next      = '0;
                    p_ptr_next      = '0;
                    issue_done_next = 1'b0;
                end
            end
            S_TSCAN:
            begin
                if (!issue_done_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_last_next = (t_ptr_reg == TGT_AW'(TGT_ENTRIES - 1));
                    ent_vld_next  = tv_reg[t_ptr_reg];
                    if (t_ptr_reg == TGT_AW'(TGT_ENTRIES - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        t_ptr_next = t_ptr_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg)
                begin
                    if (t_hit)
                    begin
                        verdict_next = V_EXACT;
                        exact_next   = exact_reg + 32'd1;
                        state_next   = S_DONE;
                        cmp_vld_next = 1'b0;
                    end
                    else if (cmp_last_reg)
                    begin
                        cmp_vld_next    = 1'b0;
                        issue_done_next = 1'b0;
                        state_next      = prefix_en ? S_PSCAN : S_DONE;
                    end
                end
            end
            S_PSCAN:
            begin
                if (!issue_done_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_last_next = (p_ptr_reg == PFX_AW'(PFX_ENTRIES - 1));
                    ent_vld_next  = pv_reg[p_ptr_reg];
                    if (p_ptr_reg == PFX_AW'(PFX_ENTRIES - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        p_ptr_next = p_ptr_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg)
                begin
                    if (p_hit)
                    begin
                        verdict_next = V_PREFIX;
                        class_next   = p_rdata.dev_class;
                        pfx_cnt_next = pfx_cnt_reg + 32'd1;
                        state_next   = S_DONE;
                        cmp_vld_next = 1'b0;
                    end
                    else if (cmp_last_reg)
                    begin
                        cmp_vld_next = 1'b0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            t_ptr_reg      <= '0;
            p_ptr_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            ent_vld_reg    <= 1'b0;
            tv_reg         <= '0;
            pv_reg         <= '0;
            scans_reg      <= '0;
            exact_reg      <= '0;
            pfx_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            t_ptr_reg      <= t_ptr_next;
            p_ptr_reg      <= p_ptr_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_last_reg   <= cmp_last_next;
            ent_vld_reg    <= ent_vld_next;
            tv_reg         <= tv_next;
            pv_reg         <= pv_next;
            scans_reg      <= scans_next;
            exact_reg      <= exact_next;
            pfx_cnt_reg    <= pfx_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        sig_reg     <= sig_next;
        verdict_reg <= verdict_next;
        class_reg   <= class_next;
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);

    assign res = '{verdict: verdict_reg, hit_address: addr_reg, hit_signal_dbm: sig_reg,
                   hit_class: class_reg, scan_count: scans_reg, exact_count: exact_reg,
                   prefix_count: pfx_cnt_reg};

endmodule

// File: design/mac_exact_and_prefix_classifier.sv
// Top level of the exact and prefix address classifier: channel handshakes,
// the enable register and the output register. Depends on mac_cls_pkg, mac_cls_engine.
`timescale 1ns / 1ps

// A load word writes one table slot in the cycle it is accepted, and ready stays
// high, so loads go at one word per cycle. A classify word walks the exact table and
// then, on a miss with prefix matching enabled, the prefix table, one entry per cycle
// through each table's single read port, whose read data is registered. Ready drops
// for the walk, which stops at the first exact hit and leaves out the prefix table
// on a miss with prefix matching off. The result word moves into an output register,
// so the next word is taken while it waits there; if that register is still full
// when a walk ends, ready stays low until it drains. Both tables' valid bits clear
// at reset.
module mac_exact_and_prefix_classifier (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mac_cls_pkg::in_word_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mac_cls_pkg::out_word_t out_data,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata
);
    import mac_cls_pkg::*;

    logic      pfx_en_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg;
    eng_stat_t stat;
    out_word_t res;
    logic      start;
    logic      res_take;

    assign in_ready = stat.idle;
    assign start    = in_valid && in_ready;
    assign res_take = stat.res_valid && (!out_valid_reg || out_ready);

    mac_cls_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (in_data),
        .prefix_en (pfx_en_reg),
        .res_take  (res_take),
        .stat      (stat),
        .res       (res)
    );

    // Prefix-match enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfx_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            pfx_en_reg <= cfg_wdata;
        end
    end

    // Output register: loads a finished result when empty or being drained.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: design/mac_cls_checker.sv
// Port-level checker of the classifier and its bind to the top level.
// Depends on mac_cls_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mac_cls_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input mac_cls_pkg::in_word_t  in_data,
    input logic                   out_valid,
    input logic                   out_ready,
    input mac_cls_pkg::out_word_t out_data
);
    import mac_cls_pkg::*;

    // A stalled result word holds.
    `MAC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

    // A classify word closes the input until its walk is over.
    `MAC_ASSERT_NXT(a_cls_busy, in_valid && in_ready && (in_data.req_type == REQ_CLASSIFY), !in_ready, "input still open after a classify word")

    // Only a prefix hit carries a class.
    `MAC_ASSERT_IMP(a_class_zero, out_valid && (out_data.verdict != V_PREFIX), out_data.hit_class == 8'd0, "class set without a prefix hit")

    // Every result follows at least one classify word.
    `MAC_ASSERT(a_scan_nonzero, !out_valid || (out_data.scan_count != 32'd0), "result with a zero scan count")

endmodule

bind mac_exact_and_prefix_classifier mac_cls_checker u_mac_cls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/tb_mac_exact_and_prefix_classifier.sv
// Self-checking testbench for the exact and prefix address classifier: a directed
// table of words followed by random phases, checked against a behavioral table model.
// Depends on mac_cls_pkg and mac_exact_and_prefix_classifier.
`timescale 1ns / 1ps

module tb_mac_exact_and_prefix_classifier;

    import mac_cls_pkg::*;

    // Request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RAND_PHASES     = 7;
    localparam int PHASE_WORDS     = 250;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int MAX_REPORTS     = 40;

    typedef struct {
        bit        is_cfg;
        bit        cfg_val;
        in_word_t  w;
        bit        typed;
        out_word_t res;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    // Model copy of the tables, counters and enable register.
    logic [47:0] tgt_addr  [TGT_ENTRIES];
    logic        tgt_valid [TGT_ENTRIES];
    logic [47:0] pfx_addr  [PFX_ENTRIES];
    logic [3:0]  pfx_len   [PFX_ENTRIES];
    logic [7:0]  pfx_class [PFX_ENTRIES];
    logic        pfx_valid [PFX_ENTRIES];
    logic [31:0] scans_seen  = '0;
    logic [31:0] exact_hits  = '0;
    logic [31:0] prefix_hits = '0;
    logic        pfx_enable  = 1'b1;

    out_word_t awaited_verdicts [$];
    dir_row_t  dir_rows [$];
    int        mismatches = 0;
    bit        hold_rx    = 1'b0;
    int        tx_streak  = 0;
    int        rx_streak  = 0;

    mac_exact_and_prefix_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TGT_ENTRIES; i++)
        begin
            tgt_addr[i]  = '0;
            tgt_valid[i] = 1'b0;
        end
        for (int i = 0; i < PFX_ENTRIES; i++)
        begin
            pfx_addr[i]  = '0;
            pfx_len[i]   = '0;
            pfx_class[i] = '0;
            pfx_valid[i] = 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Appends one row to the directed table.
    task automatic add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // Applies one word to the model tables; a classify word yields its result word.
    task automatic classify_against_tables(input in_word_t w, output bit gives,
                                           output out_word_t res);
        bit found;
        int shift;
        found = 1'b0;
        gives = 1'b0;
        res   = '0;
        case (w.req_type)
            REQ_LOAD_EXACT:
            begin
                tgt_addr[w.entry_index]  = w.address;
                tgt_valid[w.entry_index] = w.entry_valid;
            end
            REQ_LOAD_PREFIX:
            begin
                pfx_addr[w.entry_index]  = w.address;
                pfx_len[w.entry_index]   = w.prefix_digits;
                pfx_class[w.entry_index] = w.device_class;
                pfx_valid[w.entry_index] = w.entry_valid;
            end
            REQ_CLASSIFY:
            begin
                gives = 1'b1;
                scans_seen++;
                res.verdict = V_NONE;
                for (int i = 0; i < TGT_ENTRIES && !found; i++)
                    if (tgt_valid[i] && tgt_addr[i] == w.address)
                        found = 1'b1;
                if (found)
                begin
                    res.verdict = V_EXACT;
                    exact_hits++;
                end
                else if (pfx_enable)
                begin
                    // Lowest valid slot whose top digits agree; a length past twelve never hits.
                    for (int i = 0; i < PFX_ENTRIES && !found; i++)
                    begin
                        shift = ADDR_W - 4 * int'(pfx_len[i]);
                        if (pfx_valid[i] && pfx_len[i] <= ADDR_DIGITS &&
                            (((w.address ^ pfx_addr[i]) >> shift) == 48'd0))
                        begin
                            found         = 1'b1;
                            res.verdict   = V_PREFIX;
                            res.hit_class = pfx_class[i];
                        end
                    end
                    if (found)
                        prefix_hits++;
                end
                res.hit_address    = w.address;
                res.hit_signal_dbm = w.signal_dbm;
                res.scan_count     = scans_seen;
                res.exact_count    = exact_hits;
                res.prefix_count   = prefix_hits;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic in_word_t mk_word(input logic [1:0] req, input logic [47:0] addr,
                                         input logic [3:0] idx, input logic valid,
                                         input logic [3:0] digits, input logic [7:0] cls,
                                         input logic [7:0] sig);
        in_word_t w;
        w.req_type      = req;
        w.address       = addr;
        w.entry_index   = idx;
        w.entry_valid   = valid;
        w.prefix_digits = digits;
        w.device_class  = cls;
        w.signal_dbm    = sig;
        return w;
    endfunction

    function automatic dir_row_t word_row(input in_word_t w);
        dir_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = 1'b0;
        r.w       = w;
        r.typed   = 1'b0;
        r.res     = '0;
        return r;
    endfunction

    // A classify row whose result is written out by hand.
    function automatic dir_row_t typed_row(input logic [47:0] addr, input logic [7:0] sig,
                                           input logic [1:0] v, input logic [7:0] cls,
                                           input logic [31:0] sc, input logic [31:0] ec,
                                           input logic [31:0] pc);
        dir_row_t r;
        r       = word_row(mk_word(REQ_CLASSIFY, addr, 4'd0, 1'b0, 4'd0, 8'd0, sig));
        r.typed = 1'b1;
        r.res.verdict        = v;
        r.res.hit_address    = addr;
        r.res.hit_signal_dbm = sig;
        r.res.hit_class      = cls;
        r.res.scan_count     = sc;
        r.res.exact_count    = ec;
        r.res.prefix_count   = pc;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input bit en);
        dir_row_t r;
        r         = word_row('0);
        r.is_cfg  = 1'b1;
        r.cfg_val = en;
        return r;
    endfunction

    // Sender gaps: mostly none or short, a few long, with gap-free streaks.
    function automatic int pick_tx_gap();
        int r;
        if (tx_streak > 0)
        begin
            tx_streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            tx_streak = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic int pick_rx_stall();
        int r;
        if (rx_streak > 0)
        begin
            rx_streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            rx_streak = $urandom_range(50, 200);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random word biased so that classify words often hit loaded entries.
    function automatic in_word_t random_word();
        in_word_t    w;
        int          r;
        int          slot;
        logic [47:0] hi;
        w.address       = 48'({$urandom(), $urandom()});
        w.entry_index   = 4'($urandom_range(0, 15));
        w.entry_valid   = ($urandom_range(0, 99) < 80);
        w.device_class  = 8'($urandom_range(0, 255));
        w.signal_dbm    = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 6)
            w.prefix_digits = 4'd0;
        else if (r < 12)
            w.prefix_digits = 4'($urandom_range(13, 15));
        else
            w.prefix_digits = 4'($urandom_range(1, 12));
        slot = $urandom_range(0, 15);
        r    = $urandom_range(0, 99);
        if (r < 2)
            w.req_type = REQ_UNUSED;
        else if (r < 24)
        begin
            w.req_type = REQ_LOAD_EXACT;
            if ($urandom_range(0, 3) == 0)
                w.address = pfx_addr[slot];
        end
        else if (r < 46)
            w.req_type = REQ_LOAD_PREFIX;
        else
        begin
            w.req_type = REQ_CLASSIFY;
            r = $urandom_range(0, 99);
            if (r < 30)
                w.address = tgt_addr[slot];
            else if (r < 65)
            begin
                hi        = ~(48'hFFFF_FFFF_FFFF >> (4 * int'(pfx_len[slot])));
                w.address = (pfx_addr[slot] & hi) | (w.address & ~hi);
            end
        end
        return w;
    endfunction

    // Offers one word, waits for its acceptance and records the expected result.
    task automatic offer(input in_word_t w, input bit typed, input out_word_t typed_res);
        int        gap;
        bit        gives;
        out_word_t res;
        gap = pick_tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        classify_against_tables(w, gives, res);
        if (gives)
        begin
            if (typed)
                res = typed_res;
            awaited_verdicts.insert(awaited_verdicts.size(), res);
        end
    endtask

    // Stops offering until every result is back, then lets the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input bit en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we     <= 1'b0;
        pfx_enable  = en;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
            begin
                n = pick_rx_stall();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_verdicts.size() == 0)
                report_mismatch("unexpected word, address", 64'(out_data.hit_address), 64'd0);
            else
            begin
                want = awaited_verdicts.pop_front();
                if (out_data.verdict !== want.verdict)
                    report_mismatch("verdict", 64'(out_data.verdict), 64'(want.verdict));
                if (out_data.hit_address !== want.hit_address)
                    report_mismatch("hit_address", 64'(out_data.hit_address),
                                    64'(want.hit_address));
                if (out_data.hit_signal_dbm !== want.hit_signal_dbm)
                    report_mismatch("hit_signal_dbm", 64'(out_data.hit_signal_dbm),
                                    64'(want.hit_signal_dbm));
                if (out_data.hit_class !== want.hit_class)
                    report_mismatch("hit_class", 64'(out_data.hit_class), 64'(want.hit_class));
                if (out_data.scan_count !== want.scan_count)
                    report_mismatch("scan_count", 64'(out_data.scan_count),
                                    64'(want.scan_count));
                if (out_data.exact_count !== want.exact_count)
                    report_mismatch("exact_count", 64'(out_data.exact_count),
                                    64'(want.exact_count));
                if (out_data.prefix_count !== want.prefix_count)
                    report_mismatch("prefix_count", 64'(out_data.prefix_count),
                                    64'(want.prefix_count));
            end
        end
    end

    // Watchdog: too long without any accepted word ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_mac_exact_and_prefix_classifier: FAIL");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final drain.
    initial
    begin
        in_word_t w;
        int       done;

        // Empty tables, extremes, exact over prefix, zero-digit and over-long
        // prefixes, cleared slots, an unused request code and both enable values.
        add_row(cfg_row(1'b1));
        add_row(typed_row(48'h0000_0000_0000, 8'h80, V_NONE, 8'h00, 1, 0, 0));
        add_row(typed_row(48'hFFFF_FFFF_FFFF, 8'h7F, V_NONE, 8'h00, 2, 0, 0));
        add_row(word_row(mk_word(REQ_LOAD_EXACT, 48'hFFFF_FFFF_FFFF, 4'd0,
                                 1'b1, 4'd0, 8'h00, 8'h00)));
        add_row(word_row(mk_word(REQ_LOAD_EXACT, 48'h0011_2233_4455, 4'd15,
                                 1'b1, 4'd15, 8'hFF, 8'hFF)));
        add_row(typed_row(48'hFFFF_FFFF_FFFF, 8'hFF, V_EXACT, 8'h00, 3, 1, 0));
        add_row(typed_row(48'h0011_2233_4455, 8'h00, V_EXACT, 8'h00, 4, 2, 0));
        add_row(word_row(mk_word(REQ_LOAD_EXACT, 48'h0011_2233_4455, 4'd15,
                                 1'b0, 4'd0, 8'h00, 8'h00)));
        add_row(typed_row(48'h0011_2233_4455, 8'hC4, V_NONE, 8'h00, 5, 2, 0));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'hA4C1_3800_0000, 4'd3,
                                 1'b1, 4'd6, 8'h5A, 8'h00)));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'h0000_0000_0000, 4'd7,
                                 1'b1, 4'd0, 8'hFF, 8'h00)));
        add_row(typed_row(48'hA4C1_3812_3456, 8'hB0, V_PREFIX, 8'h5A, 6, 2, 1));
        add_row(typed_row(48'h1234_5678_9ABC, 8'h01, V_PREFIX, 8'hFF, 7, 2, 2));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'h1234_5678_9ABC, 4'd1,
                                 1'b1, 4'd12, 8'h01, 8'h00)));
        add_row(typed_row(48'h1234_5678_9ABC, 8'h02, V_PREFIX, 8'h01, 8, 2, 3));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'h0F0F_0F0F_0F0F, 4'd2,
                                 1'b1, 4'd15, 8'h22, 8'h00)));
        add_row(typed_row(48'h0F0F_0F0F_0F0F, 8'hD8, V_PREFIX, 8'hFF, 9, 2, 4));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'h0000_0000_0000, 4'd7,
                                 1'b0, 4'd0, 8'hFF, 8'h00)));
        add_row(typed_row(48'h0F0F_0F0F_0F0F, 8'h55, V_NONE, 8'h00, 10, 2, 4));
        add_row(word_row(mk_word(REQ_UNUSED, 48'hFFFF_FFFF_FFFF, 4'd15,
                                 1'b1, 4'd15, 8'hFF, 8'h7F)));
        add_row(word_row(mk_word(REQ_LOAD_PREFIX, 48'hFFFF_FF00_0000, 4'd0,
                                 1'b1, 4'd6, 8'h77, 8'h00)));
        add_row(typed_row(48'hFFFF_FFFF_FFFF, 8'hAA, V_EXACT, 8'h00, 11, 3, 4));
        add_row(typed_row(48'hFFFF_FF00_0001, 8'h33, V_PREFIX, 8'h77, 12, 3, 5));
        add_row(cfg_row(1'b0));
        add_row(typed_row(48'hFFFF_FF00_0001, 8'h80, V_NONE, 8'h00, 13, 3, 5));
        add_row(typed_row(48'hFFFF_FFFF_FFFF, 8'h7F, V_EXACT, 8'h00, 14, 4, 5));
        add_row(cfg_row(1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
            begin
                drain_results();
                write_enable(dir_rows[k].cfg_val);
            end
            else
                offer(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].res);
        end

        // Random phases, each under its own enable setting.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            if (ph < 2)
                write_enable(ph[0]);
            else
                write_enable(1'($urandom_range(0, 1)));
            // One phase runs against a long receiver hold-off to back up the input.
            if (ph == 2)
                hold_rx = 1'b1;
            done = 0;
            while (done < PHASE_WORDS)
            begin
                w = random_word();
                offer(w, 1'b0, '0);
                if (w.req_type != REQ_UNUSED)
                    done++;
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("tb_mac_exact_and_prefix_classifier: PASS");
        else
            $display("tb_mac_exact_and_prefix_classifier: FAIL");
        $finish;
    end

endmodule
